// ===== rtl/lifo_stack_push_pop_swap_assert.svh =====
// ----------------------------------------------------------------------------
// LIFO stack assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_PUSH_POP_SWAP_ASSERT_SVH
`define LIFO_STACK_PUSH_POP_SWAP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define LSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lifo stack assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lifo stack assertion failed");

`else

`define LSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared widths, opcodes, status codes and control structs of the stack.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int STACK_DEPTH_MAX = 64;
   localparam int DATA_W          = 32;
   localparam int OP_W            = 3;
   localparam int STATUS_W        = 3;
   // Entry count reaches the depth itself, the cell index stays below it.
   localparam int CNT_W           = $clog2(STACK_DEPTH_MAX + 1);
   localparam int IDX_W           = $clog2(STACK_DEPTH_MAX);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_DUMP = 3'd1,
      OP_PEEK = 3'd2,
      OP_POP  = 3'd3,
      OP_SWAP = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_VALUE      = 3'd0,
      ST_BAD_PUSH   = 3'd1,
      ST_PEEK_EMPTY = 3'd2,
      ST_POP_EMPTY  = 3'd3,
      ST_SWAP_SHORT = 3'd4,
      ST_OVERFLOW   = 3'd5,
      ST_HALTED     = 3'd6
   } status_type;

   // Movement applied to the whole row of cells together.
   typedef enum logic [2:0] {
      SH_HOLD,
      SH_PUSH,
      SH_POP,
      SH_SWAP,
      SH_ROTATE
   } shift_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_DUMP
   } state_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      shift_cmd_type    cmd;
      logic [IDX_W-1:0] last_idx;
   } shift_ctl_type;

   // Controller state visible to the top level.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             halted;
      logic             dumping;
   } ctrl_stat_type;

endpackage

// ===== rtl/lss_cell.sv =====
// ----------------------------------------------------------------------------
// LIFO stack cell
// One stack entry; cell 0 is the top. Each cycle it holds its word or takes
// the word of a neighbor (or of the top entry when rotating) as the broadcast shift command selects.
// ----------------------------------------------------------------------------
module lss_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                       clock,
   input  lss_pkg::shift_ctl_type     ctl,
   input  logic [lss_pkg::DATA_W-1:0] up_data,
   input  logic [lss_pkg::DATA_W-1:0] down_data,
   input  logic [lss_pkg::DATA_W-1:0] top_data,
   output logic [lss_pkg::DATA_W-1:0] data
);

   logic [lss_pkg::DATA_W-1:0] data_ff;
   logic [lss_pkg::DATA_W-1:0] data_in;
   logic                       is_last;
   logic                       below_last;

   assign is_last    = (ctl.last_idx == lss_pkg::IDX_W'(CELL_INDEX));
   assign below_last = (lss_pkg::IDX_W'(CELL_INDEX) < ctl.last_idx);

   // Select the next word for this entry.
   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         lss_pkg::SH_PUSH: begin
            data_in = up_data;
         end
         lss_pkg::SH_POP: begin
            data_in = down_data;
         end
         lss_pkg::SH_SWAP: begin
            if (CELL_INDEX == 0) begin
               data_in = down_data;
            end else if (CELL_INDEX == 1) begin
               data_in = up_data;
            end
         end
         lss_pkg::SH_ROTATE: begin
            // The occupied entries turn one place toward the top.
            if (below_last) begin
               data_in = down_data;
            end else if (is_last) begin
               data_in = top_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Entry storage carries no reset; unused entries are never read.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// LIFO stack controller
// Decodes each request, keeps the entry count and halt flag, sequences the
// dump and holds the response register.
// ----------------------------------------------------------------------------
module lss_ctrl #(
   parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lss_pkg::OP_W-1:0]     req_op,
   input  logic                         req_push_valid,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lss_pkg::DATA_W-1:0]   rsp_value,
   output logic [lss_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last,
   input  logic [lss_pkg::DATA_W-1:0]   top_value,
   output lss_pkg::shift_ctl_type       ctl,
   output lss_pkg::ctrl_stat_type       stat
);

   localparam logic [lss_pkg::CNT_W-1:0] FULL_COUNT = lss_pkg::CNT_W'(STACK_DEPTH);
   localparam logic [lss_pkg::CNT_W-1:0] CNT_ONE    = lss_pkg::CNT_W'(1);
   localparam logic [lss_pkg::CNT_W-1:0] CNT_TWO    = lss_pkg::CNT_W'(2);

   lss_pkg::state_type          state_ff, state_in;
   logic [lss_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [lss_pkg::CNT_W-1:0]   remain_ff, remain_in;
   logic                        halted_ff, halted_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lss_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   lss_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;
   logic                        out_free;
   logic                        accept;
   logic [lss_pkg::CNT_W-1:0]   count_m1;
   lss_pkg::op_type             op;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lss_pkg::FSM_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign op        = lss_pkg::op_type'(req_op);
   assign count_m1  = count_ff - CNT_ONE;

   // Next state, stack command and response load.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      halted_in     = halted_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = lss_pkg::ST_VALUE;
      rsp_last_in   = 1'b1;
      ctl.cmd       = lss_pkg::SH_HOLD;
      ctl.last_idx  = count_m1[lss_pkg::IDX_W-1:0];
      unique case (state_ff)
         lss_pkg::FSM_IDLE: begin
            if (accept) begin
               if (halted_ff) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = lss_pkg::ST_HALTED;
               end else begin
                  unique case (op)
                     lss_pkg::OP_PUSH: begin
                        if (count_ff == FULL_COUNT) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = lss_pkg::ST_OVERFLOW;
                           halted_in     = 1'b1;
                        end else if (!req_push_valid) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = lss_pkg::ST_BAD_PUSH;
                           halted_in     = 1'b1;
                        end else begin
                           ctl.cmd  = lss_pkg::SH_PUSH;
                           count_in = count_ff + CNT_ONE;
                        end
                     end
                     lss_pkg::OP_DUMP: begin
                        if (count_ff != '0) begin
                           state_in  = lss_pkg::FSM_DUMP;
                           remain_in = count_ff;
                        end
                     end
                     lss_pkg::OP_PEEK: begin
                        rsp_load = 1'b1;
                        if (count_ff == '0) begin
                           rsp_status_in = lss_pkg::ST_PEEK_EMPTY;
                           halted_in     = 1'b1;
                        end else begin
                           rsp_value_in = top_value;
                        end
                     end
                     lss_pkg::OP_POP: begin
                        if (count_ff == '0) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = lss_pkg::ST_POP_EMPTY;
                           halted_in     = 1'b1;
                        end else begin
                           ctl.cmd  = lss_pkg::SH_POP;
                           count_in = count_m1;
                        end
                     end
                     lss_pkg::OP_SWAP: begin
                        if (count_ff < CNT_TWO) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = lss_pkg::ST_SWAP_SHORT;
                           halted_in     = 1'b1;
                        end else begin
                           ctl.cmd = lss_pkg::SH_SWAP;
                        end
                     end
                     default: begin
                        // Unused opcodes are dropped.
                     end
                  endcase
               end
            end
         end
         lss_pkg::FSM_DUMP: begin
            // Emit the top and turn the stack so the next entry comes up.
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = top_value;
               rsp_last_in  = (remain_ff == CNT_ONE);
               ctl.cmd      = lss_pkg::SH_ROTATE;
               remain_in    = remain_ff - CNT_ONE;
               if (remain_ff == CNT_ONE) begin
                  state_in = lss_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = lss_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lss_pkg::FSM_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;
   assign stat.count   = count_ff;
   assign stat.halted  = halted_ff;
   assign stat.dumping = (state_ff == lss_pkg::FSM_DUMP);

endmodule

// ===== rtl/lifo_stack_push_pop_swap.sv =====
// Push, pop, swap and peek are accepted back to back while the response
// register is free or being drained.
// During a dump the row of cells rotates once per emitted entry and ends in
// its original order, and requests wait meanwhile.
// Synchronous active-high reset empties the stack and clears the halt flag.
// ----------------------------------------------------------------------------
// LIFO stack top level
// Bounded stack of signed words built as a row of shifting cells.
// ----------------------------------------------------------------------------
`include "lifo_stack_push_pop_swap_assert.svh"

module lifo_stack_push_pop_swap #(
   parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lss_pkg::OP_W-1:0]            req_op,
   input  logic signed [lss_pkg::DATA_W-1:0]   req_push_value,
   input  logic                                req_push_valid,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lss_pkg::DATA_W-1:0]   rsp_out_value,
   output logic [lss_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_last
);

   lss_pkg::shift_ctl_type     ctl;
   lss_pkg::ctrl_stat_type     stat;
   logic [lss_pkg::DATA_W-1:0] cell_data [STACK_DEPTH];
   logic [lss_pkg::DATA_W-1:0] push_word;
   logic [lss_pkg::DATA_W-1:0] rsp_word;

   assign push_word     = $unsigned(req_push_value);
   assign rsp_out_value = $signed(rsp_word);

   // Request decode, counters and response register.
   lss_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_valid (req_push_valid),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_word),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .top_value      (cell_data[0]),
      .ctl            (ctl),
      .stat           (stat)
   );

   // Row of cells, top of stack at index zero.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [lss_pkg::DATA_W-1:0] up_word;
      logic [lss_pkg::DATA_W-1:0] down_word;

      if (i == 0) begin : g_top
         assign up_word = push_word;
      end else begin : g_mid_up
         assign up_word = cell_data[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign down_word = cell_data[i];
      end else begin : g_mid_down
         assign down_word = cell_data[i+1];
      end

      lss_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .up_data   (up_word),
         .down_data (down_word),
         .top_data  (cell_data[0]),
         .data      (cell_data[i])
      );
   end

   // Checks on the controller and the cell row.
   `LSS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, stat.count <= lss_pkg::CNT_W'(STACK_DEPTH))
   `LSS_ASSERT_NXT(a_halt_sticky, clock, reset, stat.halted, stat.halted)
   `LSS_ASSERT_IMP(a_dump_blocks, clock, reset, stat.dumping, !req_ready)
   `LSS_ASSERT_NXT(a_push_lands, clock, reset, req_valid && req_ready && !stat.halted && (req_op == lss_pkg::OP_PUSH) && req_push_valid && (stat.count != lss_pkg::CNT_W'(STACK_DEPTH)), cell_data[0] == $past(push_word))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack testbench
// Sends opcode requests with random gaps, predicts every response from a
// local copy of the stack and checks each response as it is accepted.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH = lss_pkg::STACK_DEPTH_DEF;
   localparam logic [lss_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [lss_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam logic signed [lss_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [lss_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam int IDLE_LIMIT      = 3000;
   localparam int RANDOM_REQUESTS = 30;
   localparam int HALTED_REQUESTS = 12;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int REPORT_LINES    = 100;
   localparam int SETTLE_CYCLES   = 20;

   typedef struct {
      logic signed [lss_pkg::DATA_W-1:0] value;
      lss_pkg::status_type               status;
      logic                              is_last;
   } stack_rsp_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [lss_pkg::OP_W-1:0]          req_op;
   logic signed [lss_pkg::DATA_W-1:0] req_push_value;
   logic                              req_push_valid;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [lss_pkg::DATA_W-1:0] rsp_out_value;
   logic [lss_pkg::STATUS_W-1:0]      rsp_status;
   logic                              rsp_last;

   // Local copy of the stack, updated on every accepted request.
   logic signed [lss_pkg::DATA_W-1:0] stack_mem [DEPTH];
   int                                stack_count = 0;
   bit                                stack_halted = 1'b0;
   stack_rsp_type                     expected_rsps [$];

   int                  mismatch_count = 0;
   int                  requests_sent = 0;
   int                  rsp_checked = 0;
   int                  stack_peak = 0;
   int                  halted_answers = 0;
   int                  idle_cycles = 0;
   int unsigned         hold_off_left = 0;
   bit                  quiet_mode = 1'b0;
   lss_pkg::status_type halt_cause = lss_pkg::ST_VALUE;

   lifo_stack_push_pop_swap i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .req_push_valid (req_push_valid),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [lss_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic random_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic report_mismatch(input string msg);
      // Keep the log bounded when the block is badly broken.
      if (mismatch_count < REPORT_LINES) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   function automatic void expect_rsp(input logic signed [lss_pkg::DATA_W-1:0] value,
                                      input lss_pkg::status_type status,
                                      input logic is_last);
      stack_rsp_type item;
      item.value   = value;
      item.status  = status;
      item.is_last = is_last;
      expected_rsps.push_back(item);
   endfunction

   // Applies one accepted request to the local stack and queues its responses.
   function automatic void predict_stack(input logic [lss_pkg::OP_W-1:0] op,
                                         input logic signed [lss_pkg::DATA_W-1:0] value,
                                         input logic operand_ok);
      logic signed [lss_pkg::DATA_W-1:0] tmp;
      if (stack_halted) begin
         expect_rsp('0, lss_pkg::ST_HALTED, 1'b1);
         halted_answers++;
      end else begin
         case (op)
            lss_pkg::OP_PUSH: begin
               // A full stack is reported before the operand is looked at.
               if (stack_count >= DEPTH) begin
                  stack_halted = 1'b1;
                  expect_rsp('0, lss_pkg::ST_OVERFLOW, 1'b1);
               end else if (!operand_ok) begin
                  stack_halted = 1'b1;
                  expect_rsp('0, lss_pkg::ST_BAD_PUSH, 1'b1);
               end else begin
                  stack_mem[stack_count] = value;
                  stack_count++;
                  if (stack_count > stack_peak) stack_peak = stack_count;
               end
            end
            lss_pkg::OP_DUMP: begin
               for (int k = stack_count - 1; k >= 0; k--) begin
                  expect_rsp(stack_mem[k], lss_pkg::ST_VALUE, k == 0);
               end
            end
            lss_pkg::OP_PEEK: begin
               if (stack_count == 0) begin
                  stack_halted = 1'b1;
                  expect_rsp('0, lss_pkg::ST_PEEK_EMPTY, 1'b1);
               end else begin
                  expect_rsp(stack_mem[stack_count - 1], lss_pkg::ST_VALUE, 1'b1);
               end
            end
            lss_pkg::OP_POP: begin
               if (stack_count == 0) begin
                  stack_halted = 1'b1;
                  expect_rsp('0, lss_pkg::ST_POP_EMPTY, 1'b1);
               end else begin
                  stack_count--;
               end
            end
            lss_pkg::OP_SWAP: begin
               if (stack_count < 2) begin
                  stack_halted = 1'b1;
                  expect_rsp('0, lss_pkg::ST_SWAP_SHORT, 1'b1);
               end else begin
                  tmp = stack_mem[stack_count - 1];
                  stack_mem[stack_count - 1] = stack_mem[stack_count - 2];
                  stack_mem[stack_count - 2] = tmp;
               end
            end
            default: begin
               // Spare opcodes are ignored.
            end
         endcase
      end
   endfunction

   // Checks the accepted response first, then predicts the accepted request.
   always @(posedge clock) begin : stack_monitor
      stack_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response: value %0d status %0d last %0b",
                                         rsp_out_value, rsp_status, rsp_last));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_out_value !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_out_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_last !== want.is_last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_last, want.is_last));
               rsp_checked++;
            end
         end
         if (req_valid && req_ready) begin
            predict_stack(req_op, req_push_value, req_push_valid);
         end
      end
   end

   // Ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: random stalls, quiet stretches and a requested hold-off.
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_mode) stall_left = pick_gap();
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so the caller either sends again at once or lowers it.
   task automatic send_request(input logic [lss_pkg::OP_W-1:0] op,
                               input logic signed [lss_pkg::DATA_W-1:0] value,
                               input logic operand_ok);
      int unsigned gap;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      req_push_valid <= operand_ok;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   // Extreme operands, every opcode and the top-two exchange.
   task automatic test_basic_ops();
      send_request(lss_pkg::OP_PUSH, WORD_MAX, 1'b1);
      send_request(lss_pkg::OP_PUSH, WORD_MIN, 1'b1);
      send_request(lss_pkg::OP_PUSH, '0, 1'b1);
      send_request(lss_pkg::OP_PUSH, '1, 1'b1);
      send_request(lss_pkg::OP_PUSH, 32'sh5555_5555, 1'b1);
      send_request(lss_pkg::OP_PUSH, 32'shaaaa_aaaa, 1'b1);
      send_request(lss_pkg::OP_PEEK, random_word(), 1'b0);
      send_request(lss_pkg::OP_DUMP, random_word(), 1'b1);
      send_request(lss_pkg::OP_SWAP, random_word(), 1'b0);
      send_request(lss_pkg::OP_PEEK, random_word(), 1'b1);
      send_request(lss_pkg::OP_POP, random_word(), 1'b0);
      send_request(lss_pkg::OP_POP, random_word(), 1'b1);
      send_request(lss_pkg::OP_DUMP, random_word(), 1'b0);
      wait_for_responses();
   endtask

   // Spare opcodes must leave the stack untouched.
   task automatic test_spare_opcodes();
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         send_request(lss_pkg::OP_W'(op), random_word(), random_bit());
      end
      send_request(lss_pkg::OP_PEEK, random_word(), 1'b1);
      send_request(lss_pkg::OP_DUMP, random_word(), 1'b0);
      wait_for_responses();
   endtask

   // Fill to the full depth, dump every entry, then shrink again.
   task automatic test_full_stack();
      while (stack_count < DEPTH) send_request(lss_pkg::OP_PUSH, random_word(), 1'b1);
      send_request(lss_pkg::OP_DUMP, random_word(), random_bit());
      send_request(lss_pkg::OP_PEEK, random_word(), random_bit());
      send_request(lss_pkg::OP_SWAP, random_word(), random_bit());
      while (stack_count > DEPTH - 4) send_request(lss_pkg::OP_POP, random_word(), random_bit());
      send_request(lss_pkg::OP_DUMP, random_word(), random_bit());
      wait_for_responses();
   endtask

   // The receiver stops for a long stretch while peeks and dumps keep coming.
   task automatic test_receiver_hold_off();
      while (stack_count < 3) send_request(lss_pkg::OP_PUSH, random_word(), 1'b1);
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (6) send_request(lss_pkg::OP_PEEK, random_word(), random_bit());
      send_request(lss_pkg::OP_DUMP, random_word(), random_bit());
      send_request(lss_pkg::OP_PEEK, random_word(), random_bit());
      send_request(lss_pkg::OP_DUMP, random_word(), random_bit());
      wait_for_responses();
   endtask

   // Legal sequences with random content, in randomly chosen fill or drain phases.
   task automatic test_random_sequences();
      int unsigned pick;
      bit          filling;
      filling = 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 10 == 0) filling = $urandom_range(0, 1);
         quiet_mode = (n >= 10 && n < 20);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_request(lss_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         random_word(), random_bit());
         end else if (pick < 12) begin
            send_request(lss_pkg::OP_DUMP, random_word(), random_bit());
         end else if (pick < 27 && stack_count > 0) begin
            send_request(lss_pkg::OP_PEEK, random_word(), random_bit());
         end else if (pick < 39 && stack_count >= 2) begin
            send_request(lss_pkg::OP_SWAP, random_word(), random_bit());
         end else if (stack_count < DEPTH &&
                      (stack_count == 0 || $urandom_range(0, 99) < (filling ? 75 : 25))) begin
            send_request(lss_pkg::OP_PUSH, random_word(), 1'b1);
         end else begin
            send_request(lss_pkg::OP_POP, random_word(), random_bit());
         end
      end
      quiet_mode = 1'b0;
      wait_for_responses();
   endtask

   // One error kind per run halts the stack; everything after it answers halted.
   task automatic test_halt_and_after();
      int target;
      halt_cause = lss_pkg::status_type'($urandom_range(lss_pkg::ST_BAD_PUSH,
                                                        lss_pkg::ST_OVERFLOW));
      case (halt_cause)
         lss_pkg::ST_OVERFLOW: begin
            while (stack_count < DEPTH)
               send_request(lss_pkg::OP_PUSH, random_word(), 1'b1);
            send_request(lss_pkg::OP_PUSH, random_word(), random_bit());
         end
         lss_pkg::ST_BAD_PUSH: begin
            if (stack_count == DEPTH) send_request(lss_pkg::OP_POP, random_word(), 1'b1);
            send_request(lss_pkg::OP_PUSH, random_word(), 1'b0);
         end
         lss_pkg::ST_SWAP_SHORT: begin
            target = $urandom_range(0, 1);
            while (stack_count > target) send_request(lss_pkg::OP_POP, random_word(), 1'b1);
            while (stack_count < target) send_request(lss_pkg::OP_PUSH, random_word(), 1'b1);
            send_request(lss_pkg::OP_SWAP, random_word(), random_bit());
         end
         default: begin
            while (stack_count > 0) send_request(lss_pkg::OP_POP, random_word(), 1'b1);
            send_request((halt_cause == lss_pkg::ST_PEEK_EMPTY) ? lss_pkg::OP_PEEK
                                                                : lss_pkg::OP_POP,
                         random_word(), random_bit());
         end
      endcase
      repeat (HALTED_REQUESTS) begin
         send_request(lss_pkg::OP_W'($urandom_range(lss_pkg::OP_PUSH, OP_SPARE_LAST)),
                      random_word(), random_bit());
      end
      wait_for_responses();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = lss_pkg::OP_PUSH;
      req_push_value = '0;
      req_push_valid = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_spare_opcodes();
      test_full_stack();
      test_receiver_hold_off();
      test_random_sequences();
      test_halt_and_after();

      // Let any stray response show up before the verdict.
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Checked %0d responses to %0d requests; deepest stack held %0d entries.",
               rsp_checked, requests_sent, stack_peak);
      $display("Halted by %s, then %0d requests were answered as halted.",
               halt_cause.name(), halted_answers);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
